// ===== design/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional list engine package
// Types, codes and sizes shared by the list engine and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  localparam int unsigned Capacity   = 64;
  localparam int unsigned ValueWidth = 16;
  localparam int unsigned AddrWidth  = $clog2(Capacity);
  localparam int unsigned CountWidth = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_BACK  = 3'd4,
    OP_REM_AT    = 3'd5,
    OP_READ_AT   = 3'd6,
    OP_UNUSED    = 3'd7
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]            opcode;
    logic [ValueWidth-1:0] item_value;
    logic [6:0]            position;
  } cmd_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [ValueWidth-1:0] value_out;
    logic [6:0]            length;
  } rsp_t;

endpackage

`default_nettype wire

// ===== design/positional_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// Positional list engine core
// Ordered list in one single-port synchronous RAM; inserts and removes move
// the tail one entry at a time with a read-modify-write walk.
// ----------------------------------------------------------------------------
// Flow: each entry moved costs a read, then a write back through the one RAM port;
// inserts move (length - position) entries, removes (length - position - 1), read at none.
// The result strobe is registered from S_DONE; errors go straight from idle to S_DONE.
// busy is high from accept through the strobe, so the next item is taken in the cycle
// after the strobe at the earliest.
// Reset clears length and control; RAM stays undefined. done_o cannot be stalled.
`default_nettype none

module positional_list_engine_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire ple_pkg::cmd_t  cmd_i,
  output logic                busy,
  output logic                done_o,
  output ple_pkg::rsp_t       rsp_o
);
  import ple_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_WR    = 6'b000100,
    S_PUT   = 6'b001000,
    S_GET   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic [CountWidth-1:0] idx_q, idx_d;     // walk index
  logic [CountWidth-1:0] pos_q, pos_d;     // target position
  logic                  ins_q, ins_d;     // insert (else remove)
  logic                  take_q, take_d;   // remove changes the list
  logic [ValueWidth-1:0] val_q, val_d;
  rsp_t                  rsp_q, rsp_d;
  logic                  done_q, done_d;

  // single-port RAM
  logic [ValueWidth-1:0] mem [Capacity];
  logic [ValueWidth-1:0] rdata_q;
  logic                  we, re;
  logic [AddrWidth-1:0]  addr;
  logic [ValueWidth-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata_q <= mem[addr];
  end

  logic [CountWidth-1:0] cpos;
  logic                  pos_big;

  always_comb begin
    state_d = state_q; count_d = count_q; idx_d = idx_q; pos_d = pos_q;
    ins_d = ins_q; take_d = take_q; val_d = val_q; rsp_d = rsp_q;
    done_d = 1'b0;
    we = 1'b0; re = 1'b0; addr = '0; wdata = val_q;
    cpos = '0; pos_big = 1'b0;
    case (state_q)
      S_IDLE: begin
        // no new item while the previous result is still on the strobe
        if (start && !busy) begin
          val_d = cmd_i.item_value;
          pos_big = (cmd_i.position > 7'(Capacity));
          cpos = pos_big ? CountWidth'(Capacity) + 1'b1
                         : CountWidth'(cmd_i.position);
          rsp_d.value_out = '0;
          rsp_d.length = 7'(count_q);
          rsp_d.status = ST_OK;
          case (opcode_e'(cmd_i.opcode))
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
              ins_d = 1'b1;
              if (cmd_i.opcode == OP_INS_FRONT) pos_d = '0;
              else if (cmd_i.opcode == OP_INS_BACK) pos_d = count_q;
              else pos_d = cpos;
              if (cmd_i.opcode == OP_INS_AT && (pos_big || cpos > count_q)) begin
                rsp_d.status = ST_BADPOS; done_d = 1'b1;
              end else if (count_q == CountWidth'(Capacity)) begin
                rsp_d.status = ST_FULL; done_d = 1'b1;
              end else begin
                idx_d = count_q; state_d = S_RD;
              end
            end
            OP_REM_FRONT, OP_REM_BACK, OP_REM_AT, OP_READ_AT: begin
              ins_d = 1'b0;
              take_d = (cmd_i.opcode != OP_READ_AT);
              if (cmd_i.opcode == OP_REM_FRONT) pos_d = '0;
              else if (cmd_i.opcode == OP_REM_BACK) pos_d = count_q - 1'b1;
              else pos_d = cpos;
              if (count_q == '0) begin
                rsp_d.status = ST_EMPTY; done_d = 1'b1;
              end else if ((cmd_i.opcode == OP_REM_AT || cmd_i.opcode == OP_READ_AT)
                           && (pos_big || cpos >= count_q)) begin
                rsp_d.status = ST_BADPOS; done_d = 1'b1;
              end else begin
                state_d = S_GET;
              end
            end
            default: begin
              rsp_d.status = ST_BADPOS; done_d = 1'b1;
            end
          endcase
        end
      end
      // read target entry for remove/read
      S_GET: begin
        re = 1'b1; addr = AddrWidth'(pos_q);
        idx_d = pos_q;
        state_d = S_PUT;
      end
      S_PUT: begin
        if (ins_q) begin
          // drop the new value in place
          we = 1'b1; addr = AddrWidth'(pos_q); wdata = val_q;
          count_d = count_q + 1'b1;
          rsp_d.length = 7'(count_q + 1'b1);
          state_d = S_DONE;
        end else begin
          rsp_d.value_out = rdata_q;
          if (take_q && idx_q + 1'b1 < count_q) begin
            idx_d = idx_q + 1'b1; state_d = S_RD;
          end else begin
            if (take_q) begin
              count_d = count_q - 1'b1;
              rsp_d.length = 7'(count_q - 1'b1);
            end
            state_d = S_DONE;
          end
        end
      end
      // shift walk: read neighbor
      S_RD: begin
        if (ins_q) begin
          if (idx_q > pos_q) begin
            re = 1'b1; addr = AddrWidth'(idx_q - 1'b1); state_d = S_WR;
          end else begin
            state_d = S_PUT;
          end
        end else begin
          re = 1'b1; addr = AddrWidth'(idx_q); state_d = S_WR;
        end
      end
      // shift walk: write it one place over
      S_WR: begin
        we = 1'b1; wdata = rdata_q;
        if (ins_q) begin
          addr = AddrWidth'(idx_q);
          idx_d = idx_q - 1'b1; state_d = S_RD;
        end else begin
          addr = AddrWidth'(idx_q - 1'b1);
          if (idx_q + 1'b1 < count_q) begin
            idx_d = idx_q + 1'b1; state_d = S_RD;
          end else begin
            count_d = count_q - 1'b1;
            rsp_d.length = 7'(count_q - 1'b1);
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        done_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      idx_q   <= '0;
      pos_q   <= '0;
      ins_q   <= 1'b0;
      take_q  <= 1'b0;
    end else begin
      state_q <= (done_d && state_q == S_IDLE) ? S_DONE : state_d;
      count_q <= count_d;
      done_q  <= (state_q == S_DONE);
      idx_q   <= idx_d;
      pos_q   <= pos_d;
      ins_q   <= ins_d;
      take_q  <= take_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rsp_q <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE) || done_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// ===== design/ple_checker.sv =====
// ----------------------------------------------------------------------------
// Positional list engine checker
// Port-level checks on the core's command and result behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done_o,
  input wire ple_pkg::rsp_t rsp_o
);
  import ple_pkg::*;

  // accepted command raises busy next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised");

  // a result only comes while busy is high
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result outside command");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("double result");

  // value is zero unless ok
  a_val_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != ST_OK |-> rsp_o.value_out == '0)
    else $error("value on error");

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.length <= 7'(Capacity)) else $error("length overflow");

endmodule

bind positional_list_engine_core ple_checker u_ple_checker (.*);

`default_nettype wire

// ===== sim/tb_positional_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives list commands through the start/busy handshake, predicts each
// response with a behavioral copy of the list and checks every done strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_positional_list_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  // Behavioral copy of the list plus a queue of predicted responses
  class list_scoreboard;
    logic [ValueWidth-1:0] cells[$];
    rsp_t pending_rsp[$];
    int   mismatches;

    function void note_cmd(cmd_t c);
      rsp_t r;
      int   pos;
      r = '0;
      pos = int'(c.position);
      case (opcode_e'(c.opcode))
        OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
          if (c.opcode == OP_INS_FRONT) pos = 0;
          else if (c.opcode == OP_INS_BACK) pos = cells.size();
          if (pos > cells.size()) r.status = ST_BADPOS;
          else if (cells.size() >= Capacity) r.status = ST_FULL;
          else begin
            cells.insert(pos, c.item_value);
            r.status = ST_OK;
          end
        end
        OP_REM_FRONT, OP_REM_BACK, OP_REM_AT, OP_READ_AT: begin
          if (c.opcode == OP_REM_FRONT) pos = 0;
          else if (c.opcode == OP_REM_BACK) pos = cells.size() - 1;
          if (cells.size() == 0) r.status = ST_EMPTY;
          else if (pos >= cells.size()) r.status = ST_BADPOS;
          else begin
            r.status = ST_OK;
            r.value_out = cells[pos];
            if (c.opcode != OP_READ_AT) cells.delete(pos);
          end
        end
        default: r.status = ST_BADPOS;
      endcase
      r.length = 7'(cells.size());
      pending_rsp.push_back(r);
    endfunction

    function void check_rsp(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", got);
        return;
      end
      want = pending_rsp.pop_front();
      if (got.status !== want.status || got.value_out !== want.value_out ||
          got.length !== want.length) begin
        mismatches++;
        if (mismatches <= 10)
          $display("response mismatch: status %0d/%0d value %h/%h length %0d/%0d",
                   want.status, got.status, want.value_out, got.value_out,
                   want.length, got.length);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  cmd_t cmd_i;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  list_scoreboard sb;

  positional_list_engine_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Response monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_rsp(rsp_o);
  end

  // Issue one command and hold it until the block takes it
  task automatic issue_cmd(opcode_e op, logic [15:0] val, logic [6:0] pos, bit gaps);
    cmd_t c;
    int   idle;
    c.opcode = op;
    c.item_value = val;
    c.position = pos;
    idle = gaps ? $urandom_range(0, 15) : 0;
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_cmd(c);
  endtask

  // Idle cycle with junk on the command bus
  task automatic drop_start();
    cmd_t junk;
    junk = '0;
    junk.opcode = 3'($urandom);
    junk.item_value = 16'($urandom);
    junk.position = 7'($urandom);
    start <= 1'b0;
    cmd_i <= junk;
    @(posedge clk_i);
  endtask

  // Pick a position that is usually legal for the current length
  function automatic logic [6:0] pick_pos(bit for_insert);
    int n;
    n = sb.cells.size();
    case ($urandom_range(0, 9))
      0: return 7'($urandom_range(0, 127));
      1: return 7'(n);
      2: return 7'($urandom_range(n, 64));
      default: return 7'($urandom_range(0, (for_insert || n == 0) ? n : n - 1));
    endcase
  endfunction

  initial begin
    int    wait_cycles;
    int    mode;
    bit    gaps;
    opcode_e op;
    sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-list errors, extremes, unused opcode
    issue_cmd(OP_REM_FRONT, 16'h0000, 7'd0, 0);
    issue_cmd(OP_REM_BACK, 16'hFFFF, 7'd0, 0);
    issue_cmd(OP_REM_AT, 16'h0000, 7'd127, 0);
    issue_cmd(OP_READ_AT, 16'h0000, 7'd0, 0);
    issue_cmd(OP_INS_AT, 16'h1234, 7'd1, 0);
    issue_cmd(OP_INS_AT, 16'hFFFF, 7'd0, 0);
    issue_cmd(OP_INS_FRONT, 16'h0000, 7'd127, 0);
    issue_cmd(OP_INS_BACK, 16'hA5A5, 7'd0, 0);
    issue_cmd(OP_INS_AT, 16'h5A5A, 7'd3, 0);
    issue_cmd(OP_READ_AT, 16'h0000, 7'd3, 0);
    issue_cmd(OP_READ_AT, 16'h0000, 7'd4, 0);
    issue_cmd(OP_REM_AT, 16'h0000, 7'd4, 0);
    issue_cmd(OP_UNUSED, 16'hFFFF, 7'd127, 0);
    issue_cmd(OP_REM_AT, 16'h0000, 7'd1, 0);
    issue_cmd(OP_REM_BACK, 16'h0000, 7'd0, 0);
    issue_cmd(OP_REM_FRONT, 16'h0000, 7'd0, 0);
    // Fill to capacity, then overflow and check the far end
    while (sb.cells.size() < Capacity)
      issue_cmd(OP_INS_BACK, 16'($urandom), 7'd0, 0);
    issue_cmd(OP_INS_FRONT, 16'hBEEF, 7'd0, 0);
    issue_cmd(OP_INS_AT, 16'hBEEF, 7'd64, 0);
    issue_cmd(OP_INS_AT, 16'hBEEF, 7'd65, 0);
    issue_cmd(OP_READ_AT, 16'h0000, 7'd63, 0);
    issue_cmd(OP_REM_AT, 16'h0000, 7'd64, 0);
    issue_cmd(OP_REM_AT, 16'h0000, 7'd0, 0);
    issue_cmd(OP_INS_AT, 16'hC0DE, 7'd63, 0);
    drop_start();

    // Random phases: grow, drain and churn around mid-size
    for (int i = 0; i < 1650; i++) begin
      mode = (i / 150) % 3;
      gaps = ((i / 200) % 4) != 1;
      case ($urandom_range(0, 9))
        0, 1, 2: op = (mode == 1) ? OP_REM_FRONT : OP_INS_AT;
        3: op = (mode == 1) ? OP_REM_AT : OP_INS_BACK;
        4: op = (mode == 1) ? OP_REM_BACK : OP_INS_FRONT;
        5: op = OP_READ_AT;
        6: op = (mode == 0) ? OP_INS_AT : OP_REM_AT;
        7: op = OP_REM_BACK;
        8: op = opcode_e'($urandom_range(0, 6));
        default: op = opcode_e'($urandom_range(0, 7));
      endcase
      issue_cmd(op, 16'($urandom),
                pick_pos(op inside {OP_INS_FRONT, OP_INS_BACK, OP_INS_AT}), gaps);
      if ($urandom_range(0, 3) == 0) drop_start();
    end
    drop_start();

    // Drain: wait until every predicted response has been seen
    wait_cycles = 0;
    while (sb.pending_rsp.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Watchdog: ~1750 items; the run fails if not done by 10ms
  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== positional_list_engine_core.f =====
design/ple_pkg.sv
design/positional_list_engine_core.sv
design/ple_checker.sv
sim/tb_positional_list_engine_core.sv
